// File: src/ptq_pkg.sv
`timescale 1ns / 1ps
package ptq_pkg;
  localparam int Depth = 16;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int MaxRes = 16;
  localparam int ResW = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD = 2'd1,
    OP_DEL_EV = 2'd2,
    OP_DEL_CL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_IDLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] client_id;
    logic [15:0] event_code;
    logic [15:0] period;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic status;
    logic [7:0] fired_client;
    logic [15:0] fired_event;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] client;
    logic [15:0] evt;
    logic [15:0] period;
  } desc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_WAIT,
    ST_INS,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DEL,
    ST_DEL_RD,
    ST_TICK_HEAD,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_SHIFT,
    ST_TICK_END,
    ST_OUT
  } state_t;

  // request from sequencer to the order list memory
  typedef struct packed {
    logic we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } ord_req_t;
endpackage

// File: src/periodic_timer_queue_unit.sv
`timescale 1ns / 1ps
// Add scans the order list for a free slot, writes both stores at it, then walks the
// insert down from the tail; delete walks every order entry once; a tick checks the head
// and, per fired timer, shifts the order list down one place and reinserts the timer.
// Throughput: one item at a time; the next item is taken in the cycle after the last
// result of the previous one left.
// Reset: rst_n synchronous low clears time, entry count and control; the stores are
// written before any read of them.
module periodic_timer_queue_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptq_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptq_pkg::out_item_t   out_data
);
  import ptq_pkg::*;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [31:0] time_r, time_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] pos_r, pos_nxt;   // walk position
  logic [CntW-1:0] wr_r, wr_nxt;     // delete compaction pointer
  logic [Depth-1:0] used_r, used_nxt;
  logic [IdxW-1:0] slot_r, slot_nxt; // slot being inserted
  logic [31:0] dl_r, dl_nxt;         // deadline being inserted
  logic [ResW-1:0] nres_r, nres_nxt;
  out_item_t out_r, out_nxt;
  logic pend_r, pend_nxt;            // out_r holds a fired result not yet taken
  logic [IdxW-1:0] head_r, head_nxt;

  // slot-indexed stores: deadline and descriptor, read by slot number
  logic dl_we, ds_we;
  logic [IdxW-1:0] dl_waddr, st_raddr;
  logic [31:0] dl_wdata, dl_rdata;
  desc_t ds_wdata, ds_rdata;
  ord_req_t ord;
  logic [IdxW-1:0] ord_rdata;
  logic del_keep;

  ptq_ram #(.Width(32), .Words(Depth), .AddrW(IdxW)) u_dl (
    .clk, .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(st_raddr), .rdata(dl_rdata));
  ptq_ram #(.Width($bits(desc_t)), .Words(Depth), .AddrW(IdxW)) u_ds (
    .clk, .we(ds_we), .waddr(dl_waddr), .wdata(ds_wdata),
    .raddr(st_raddr), .rdata(ds_rdata));
  ptq_ram #(.Width(IdxW), .Words(Depth), .AddrW(IdxW)) u_ord (
    .clk, .we(ord.we), .waddr(ord.waddr), .wdata(ord.wdata),
    .raddr(ord.raddr), .rdata(ord_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      time_r <= '0;
      count_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      time_r <= time_nxt;
      count_r <= count_nxt;
      pend_r <= pend_nxt;
    end
    item_r <= item_nxt;
    pos_r <= pos_nxt;
    wr_r <= wr_nxt;
    used_r <= used_nxt;
    slot_r <= slot_nxt;
    dl_r <= dl_nxt;
    nres_r <= nres_nxt;
    out_r <= out_nxt;
    head_r <= head_nxt;
  end

  // first free slot from the used mask
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!used_r[i]) free_idx = IdxW'(i);
    end
  end

  // keep the entry unless client matches and, for a client+event delete, event too
  assign del_keep = !(ds_rdata.client == item_r.client_id &&
                      (op_t'(item_r.operation) == OP_DEL_CL ||
                       ds_rdata.evt == item_r.event_code));

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    time_nxt = time_r;
    count_nxt = count_r;
    pos_nxt = pos_r;
    wr_nxt = wr_r;
    used_nxt = used_r;
    slot_nxt = slot_r;
    dl_nxt = dl_r;
    nres_nxt = nres_r;
    out_nxt = out_r;
    pend_nxt = pend_r;
    head_nxt = head_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    dl_we = 1'b0;
    ds_we = 1'b0;
    dl_waddr = slot_r;
    dl_wdata = dl_r;
    ds_wdata = desc_t'{item_r.client_id, item_r.event_code, item_r.period};
    st_raddr = ord_rdata;
    ord = '0;
    ord.raddr = pos_r[IdxW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        pos_nxt = '0;
        wr_nxt = '0;
        used_nxt = '0;
        nres_nxt = '0;
        pend_nxt = 1'b0;
        ord.raddr = '0;
        if (in_valid) begin
          item_nxt = in_data;
          unique case (op_t'(in_data.operation))
            OP_TICK: begin
              time_nxt = time_r + 32'd1;
              state_nxt = ST_TICK_HEAD;
            end
            OP_ADD: begin
              if (count_r >= CntW'(Depth)) begin
                // table full: leave it as is, report full
                out_nxt = out_item_t'{KIND_ACK, 1'b1, 8'd0, 16'd0, 1'b1};
                state_nxt = ST_OUT;
              end else begin
                if (in_data.period == 16'd0) item_nxt.period = 16'd1;
                state_nxt = (count_r == '0) ? ST_ADD_WAIT : ST_ADD_SCAN;
              end
            end
            OP_DEL_EV, OP_DEL_CL: begin
              out_nxt = out_item_t'{KIND_ACK, 1'b0, 8'd0, 16'd0, 1'b1};
              state_nxt = (count_r == '0) ? ST_OUT : ST_DEL_RD;
            end
          endcase
        end
      end
      // mark slots in use, one order entry a cycle
      ST_ADD_SCAN: begin
        ord.raddr = IdxW'(pos_r + CntW'(1));
        used_nxt[ord_rdata] = 1'b1;
        pos_nxt = pos_r + CntW'(1);
        if (pos_r + CntW'(1) == count_r) state_nxt = ST_ADD_WAIT;
      end
      // write both stores at the free slot, then sort it in from the tail
      ST_ADD_WAIT: begin
        slot_nxt = free_idx;
        dl_nxt = time_r + {16'd0, item_r.period};
        dl_we = 1'b1;
        ds_we = 1'b1;
        dl_waddr = free_idx;
        dl_wdata = time_r + {16'd0, item_r.period};
        pos_nxt = count_r;
        out_nxt = out_item_t'{KIND_ACK, 1'b0, 8'd0, 16'd0, 1'b1};
        state_nxt = ST_INS;
      end
      // insert: walk down from pos, read order[pos-1] then its deadline
      ST_INS: begin
        if (pos_r == '0) begin
          ord.we = 1'b1;
          ord.waddr = '0;
          ord.wdata = slot_r;
          count_nxt = count_r + CntW'(1);
          state_nxt = (op_t'(item_r.operation) == OP_TICK) ? ST_TICK_HEAD : ST_OUT;
        end else begin
          ord.raddr = IdxW'(pos_r - CntW'(1));
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        head_nxt = ord_rdata;
        st_raddr = ord_rdata;
        state_nxt = ST_INS_CMP;
      end
      // later deadline moves up one place; equal or earlier stops the walk
      ST_INS_CMP: begin
        ord.we = 1'b1;
        ord.waddr = pos_r[IdxW-1:0];
        if (dl_rdata > dl_r) begin
          ord.wdata = head_r;
          pos_nxt = pos_r - CntW'(1);
          state_nxt = ST_INS;
        end else begin
          ord.wdata = slot_r;
          count_nxt = count_r + CntW'(1);
          state_nxt = (op_t'(item_r.operation) == OP_TICK) ? ST_TICK_HEAD : ST_OUT;
        end
      end
      // delete: order[pos] arrives, fetch its descriptor
      ST_DEL_RD: begin
        head_nxt = ord_rdata;
        st_raddr = ord_rdata;
        state_nxt = ST_DEL;
      end
      // compact survivors toward the front; wr never passes the read position
      ST_DEL: begin
        if (del_keep) begin
          ord.we = 1'b1;
          ord.waddr = wr_r[IdxW-1:0];
          ord.wdata = head_r;
          wr_nxt = wr_r + CntW'(1);
        end
        pos_nxt = pos_r + CntW'(1);
        ord.raddr = IdxW'(pos_r + CntW'(1));
        if (pos_r + CntW'(1) == count_r) begin
          count_nxt = del_keep ? wr_r + CntW'(1) : wr_r;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DEL_RD;
        end
      end
      ST_TICK_HEAD: begin
        ord.raddr = '0;
        if (count_r == '0 || nres_r == ResW'(MaxRes)) state_nxt = ST_TICK_END;
        else state_nxt = ST_TICK_RD;
      end
      ST_TICK_RD: begin
        head_nxt = ord_rdata;
        st_raddr = ord_rdata;
        state_nxt = ST_TICK_CHK;
      end
      // head due: offer the held result first, else capture this one and rearm
      ST_TICK_CHK: begin
        if (dl_rdata > time_r) begin
          state_nxt = ST_TICK_END;
        end else if (pend_r) begin
          state_nxt = ST_OUT;
        end else begin
          out_nxt = out_item_t'{KIND_FIRED, 1'b0, ds_rdata.client, ds_rdata.evt, 1'b0};
          pend_nxt = 1'b1;
          nres_nxt = nres_r + ResW'(1);
          slot_nxt = head_r;
          dl_nxt = time_r + {16'd0, ds_rdata.period};
          pos_nxt = CntW'(1);
          ord.raddr = IdxW'(1);
          state_nxt = ST_TICK_SHIFT;
        end
      end
      // drop the head: move order[1..count-1] down one place, then write new deadline
      ST_TICK_SHIFT: begin
        if (pos_r == count_r) begin
          count_nxt = count_r - CntW'(1);
          dl_we = 1'b1;
          pos_nxt = count_r - CntW'(1);
          state_nxt = ST_INS;
        end else begin
          ord.we = 1'b1;
          ord.waddr = IdxW'(pos_r - CntW'(1));
          ord.wdata = ord_rdata;
          ord.raddr = IdxW'(pos_r + CntW'(1));
          pos_nxt = pos_r + CntW'(1);
        end
      end
      ST_TICK_END: begin
        if (pend_r) out_nxt.last = 1'b1;
        else out_nxt = out_item_t'{KIND_IDLE, 1'b0, 8'd0, 16'd0, 1'b1};
        state_nxt = ST_OUT;
      end
      // hold the result until taken; a non-final fired result resumes the tick
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          pend_nxt = 1'b0;
          state_nxt = out_r.last ? ST_IDLE : ST_TICK_HEAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_data = out_r;

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth)) else $error("count overflow");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("overlap");
endmodule

// File: src/ptq_ram.sv
`timescale 1ns / 1ps
module ptq_ram #(
  parameter int Width = 8,
  parameter int Words = 16,
  parameter int AddrW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Words];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ptq_pkg::*;

  localparam int ExpSlots = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  periodic_timer_queue_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the timer table: time, per-slot deadline and descriptor,
  // and the deadline-ordered list of live slots.
  logic [31:0] now_ticks;
  logic [31:0] due_at [Depth];
  logic [7:0] slot_client [Depth];
  logic [15:0] slot_event [Depth];
  logic [15:0] slot_period [Depth];
  int order_slots [Depth];
  int live_timers;

  // expected results, ring indexed by running write and read counts
  out_item_t exp_results [ExpSlots];
  int exp_wr = 0;
  int exp_rd = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  // Flow control knobs, flipped by the main sequence and the test tasks.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic void queue_result(out_item_t r);
    exp_results[exp_wr % ExpSlots] = r;
    exp_wr++;
  endfunction

  // Insert a slot behind every live entry with a deadline at or before its own,
  // so equal deadlines keep arrival order.
  function automatic void place_slot(int s);
    int pos;
    pos = live_timers;
    while (pos > 0 && due_at[order_slots[pos-1]] > due_at[s]) begin
      order_slots[pos] = order_slots[pos-1];
      pos--;
    end
    order_slots[pos] = s;
    live_timers++;
  endfunction

  // Advance the table for one accepted item and queue the results it causes.
  function automatic void predict_timers(in_item_t it);
    out_item_t r;
    out_item_t batch [MaxRes];
    int nb;
    logic [15:0] per;
    bit used [Depth];
    int s;
    int wr;
    r = '0;
    nb = 0;
    case (op_t'(it.operation))
      OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        while (nb < MaxRes && live_timers > 0 &&
               due_at[order_slots[0]] <= now_ticks) begin
          s = order_slots[0];
          r = '0;
          r.kind = KIND_FIRED;
          r.fired_client = slot_client[s];
          r.fired_event = slot_event[s];
          batch[nb] = r;
          nb++;
          for (int i = 1; i < live_timers; i++) order_slots[i-1] = order_slots[i];
          live_timers--;
          // rearm relative to the new time
          due_at[s] = now_ticks + {16'd0, slot_period[s]};
          place_slot(s);
        end
        if (nb == 0) begin
          r = '0;
          r.kind = KIND_IDLE;
          batch[0] = r;
          nb = 1;
        end
        batch[nb-1].last = 1'b1;
        for (int i = 0; i < nb; i++) queue_result(batch[i]);
      end
      OP_ADD: begin
        r.kind = KIND_ACK;
        r.last = 1'b1;
        if (live_timers >= Depth) begin
          r.status = 1'b1;
        end else begin
          per = (it.period == 16'd0) ? 16'd1 : it.period;
          foreach (used[i]) used[i] = 1'b0;
          for (int i = 0; i < live_timers; i++) used[order_slots[i]] = 1'b1;
          s = 0;
          for (int i = Depth - 1; i >= 0; i--) if (!used[i]) s = i;
          slot_client[s] = it.client_id;
          slot_event[s] = it.event_code;
          slot_period[s] = per;
          due_at[s] = now_ticks + {16'd0, per};
          place_slot(s);
        end
        queue_result(r);
      end
      default: begin
        // compact the order list, dropping every matching timer
        wr = 0;
        for (int i = 0; i < live_timers; i++) begin
          s = order_slots[i];
          if (!(slot_client[s] == it.client_id &&
                (op_t'(it.operation) == OP_DEL_CL || slot_event[s] == it.event_code)))
          begin
            order_slots[wr] = s;
            wr++;
          end
        end
        live_timers = wr;
        r.kind = KIND_ACK;
        r.last = 1'b1;
        queue_result(r);
      end
    endcase
  endfunction

  // Offer one item, hold it until accepted, then predict. Valid is left high
  // so a following item can go out back to back.
  task automatic send_item(input op_t op, input logic [7:0] cl,
                           input logic [15:0] ev, input logic [15:0] per);
    in_item_t it;
    it.operation = op;
    it.client_id = cl;
    it.event_code = ev;
    it.period = per;
    while (tx_idle && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timers(it);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle && $urandom_range(99) < 25);
    end
  end

  // Result checker and stall watchdog.
  always @(posedge clk) begin
    out_item_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = exp_results[exp_rd % ExpSlots];
        exp_rd++;
        if (out_data.kind !== want.kind || out_data.status !== want.status ||
            out_data.fired_client !== want.fired_client ||
            out_data.fired_event !== want.fired_event || out_data.last !== want.last)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Boundary fields, zero-period clamp, both delete flavors incl. a miss.
  task automatic test_add_delete;
    send_item(OP_ADD, 8'hff, 16'hffff, 16'hffff);
    send_item(OP_ADD, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_DEL_EV, 8'h12, 16'h3456, 16'h0000);
    send_item(OP_DEL_CL, 8'hff, 16'h0000, 16'h0000);
    send_item(OP_TICK, 8'hff, 16'hffff, 16'hffff);
    send_item(OP_DEL_EV, 8'h00, 16'h0000, 16'h0000);
  endtask

  // Fill the table, overflow it, then fire all sixteen on one tick.
  task automatic test_full_table;
    for (int i = 0; i < Depth; i++) send_item(OP_ADD, 8'h01, 16'(i), 16'd1);
    send_item(OP_ADD, 8'h02, 16'h00aa, 16'd3);
    send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_DEL_CL, 8'h01, 16'h0000, 16'h0000);
    send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_item(OP_ADD, 8'h05, 16'(i), 16'd1);
    for (int i = 0; i < 6; i++) send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_DEL_CL, 8'h05, 16'h0000, 16'h0000);
  endtask

  function automatic logic [7:0] pick_client();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
  endfunction

  function automatic logic [15:0] pick_event();
    return ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3));
  endfunction

  // Random mix, small client/event pools so deletes hit; mostly short periods.
  task automatic test_random;
    int pick;
    logic [15:0] per;
    for (int n = 0; n < 95; n++) begin
      // first stretch runs with no idling on either side
      tx_idle = (n >= 40);
      rx_idle = (n >= 40);
      pick = $urandom_range(99);
      per = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      if (pick < 45) send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 78) send_item(OP_ADD, pick_client(), pick_event(), per);
      else if (pick < 90) send_item(OP_DEL_EV, pick_client(), pick_event(), 16'($urandom));
      else send_item(OP_DEL_CL, pick_client(), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    now_ticks = '0;
    live_timers = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_delete();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_full_table();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    // drain; the watchdog bounds this wait
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
